### rtl/prq_pkg.sv
// shared types, constants and helpers for the pose re-origin quaternion core
package prq_pkg;

   localparam int PosW  = 32;
   localparam int QuatW = 16;
   localparam int DiffW = PosW + 1;
   localparam int ProdW = DiffW + QuatW;
   localparam int TW    = DiffW + QuatW - 14 + 3;
   localparam int SumW  = TW + QuatW + 3;
   localparam int OSumW = 2 * QuatW + 3;
   localparam logic signed [QuatW-1:0] QOne = 16'sd16384;

   typedef struct packed {
      logic signed [PosW-1:0]  pos_x;
      logic signed [PosW-1:0]  pos_y;
      logic signed [PosW-1:0]  pos_z;
      logic signed [QuatW-1:0] quat_w;
      logic signed [QuatW-1:0] quat_x;
      logic signed [QuatW-1:0] quat_y;
      logic signed [QuatW-1:0] quat_z;
   } req_type;

   typedef struct packed {
      logic signed [PosW-1:0]  rel_x;
      logic signed [PosW-1:0]  rel_y;
      logic signed [PosW-1:0]  rel_z;
      logic signed [QuatW-1:0] rel_w;
      logic signed [QuatW-1:0] rel_qx;
      logic signed [QuatW-1:0] rel_qy;
      logic signed [QuatW-1:0] rel_qz;
      logic                    first_sample;
   } rsp_type;

   typedef struct packed {
      logic signed [QuatW-1:0] w;
      logic signed [QuatW-1:0] x;
      logic signed [QuatW-1:0] y;
      logic signed [QuatW-1:0] z;
   } quat_type;

   typedef struct packed {
      logic valid;
      logic first;
   } ctl_type;

   function automatic logic signed [TW-1:0] rnd_t(input logic signed [ProdW+1:0] v);
      logic signed [ProdW+1:0] s;
      s = v + (ProdW+2)'(8192);
      return TW'(s >>> 14);
   endfunction

   function automatic logic signed [PosW-1:0] rnd_sat_pos(input logic signed [SumW-1:0] v);
      logic signed [SumW-1:0] s;
      logic signed [SumW-1:0] r;
      s = v + SumW'(8192);
      r = s >>> 14;
      if (r > SumW'(signed'(32'h7fffffff))) return 32'sh7fffffff;
      if (r < -SumW'(signed'(33'h80000000))) return 32'sh80000000;
      return PosW'(r);
   endfunction

   function automatic logic signed [QuatW-1:0] rnd_sat_q(input logic signed [OSumW-1:0] v);
      logic signed [OSumW-1:0] s;
      logic signed [OSumW-1:0] r;
      s = v + OSumW'(8192);
      r = s >>> 14;
      if (r > OSumW'(QOne)) return QOne;
      if (r < -OSumW'(QOne)) return -QOne;
      return QuatW'(r);
   endfunction

endpackage

### rtl/pose_reorigin_quaternion_core.sv
// top level: origin latch and four-stage quaternion re-origin pipeline
//
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_ready | prq_pkg::req_type
// rsp     | out       | rsp_valid/rsp_ready | prq_pkg::rsp_type
//
// one beat per cycle sustained while rsp_ready stays high; a result is registered in stages 1 to 4 before rsp_valid
// stage 1 subtracts origin, 2 forms conj(q0)*d and conj(q0)*q products, 3 sums and rounds t,
// forms t*q0 products and sums o, 4 sums, rounds and saturates into the output register
// synchronous reset clears the valid bits and the origin flag
// a stall holds every stage that holds a beat; no beat is lost or repeated
module pose_reorigin_quaternion_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  prq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output prq_pkg::rsp_type  rsp_data
);
   localparam int DW = prq_pkg::DiffW;
   localparam int QW = prq_pkg::QuatW;
   localparam int PW = prq_pkg::ProdW;
   localparam int TW = prq_pkg::TW;
   localparam int SW = prq_pkg::SumW;
   localparam int OW = prq_pkg::OSumW;

   logic [3:0] v, ld, rdy;
   logic origin_valid_ff;
   logic signed [prq_pkg::PosW-1:0] op_ff [3];
   prq_pkg::quat_type oq_ff;

   prq_stage u_s1 (.clock, .reset, .up_valid(req_valid), .dn_ready(rdy[1]),
                   .up_ready(rdy[0]), .load(ld[0]), .valid_ff(v[0]));
   prq_stage u_s2 (.clock, .reset, .up_valid(v[0]), .dn_ready(rdy[2]),
                   .up_ready(rdy[1]), .load(ld[1]), .valid_ff(v[1]));
   prq_stage u_s3 (.clock, .reset, .up_valid(v[1]), .dn_ready(rdy[3]),
                   .up_ready(rdy[2]), .load(ld[2]), .valid_ff(v[2]));
   prq_stage u_s4 (.clock, .reset, .up_valid(v[2]), .dn_ready(rsp_ready),
                   .up_ready(rdy[3]), .load(ld[3]), .valid_ff(v[3]));

   assign req_ready = rdy[0];
   assign rsp_valid = v[3];

   // origin latch and stage 1: difference
   logic signed [DW-1:0] d1_ff [3];
   prq_pkg::quat_type q1_ff;
   logic f0_ff, f1_ff, f2_ff, f3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_valid_ff <= 1'b0;
      end else if (ld[0] && !origin_valid_ff) begin
         origin_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0] && !origin_valid_ff) begin
         op_ff[0] <= req_data.pos_x;
         op_ff[1] <= req_data.pos_y;
         op_ff[2] <= req_data.pos_z;
         oq_ff    <= {req_data.quat_w, req_data.quat_x, req_data.quat_y, req_data.quat_z};
      end
      if (ld[0]) begin
         d1_ff[0] <= DW'(req_data.pos_x) - DW'(op_ff[0]);
         d1_ff[1] <= DW'(req_data.pos_y) - DW'(op_ff[1]);
         d1_ff[2] <= DW'(req_data.pos_z) - DW'(op_ff[2]);
         q1_ff    <= {req_data.quat_w, req_data.quat_x, req_data.quat_y, req_data.quat_z};
         f0_ff    <= !origin_valid_ff;
      end
   end

   // stage 2: t = conj(q0)*(0,d) and o = conj(q0)*q products
   logic signed [PW-1:0]  tp_ff [12];
   logic signed [2*QW-1:0] op2_ff [16];
   logic signed [QW:0]   a [4];
   logic signed [QW-1:0] b [4];
   logic signed [DW-1:0] dd [4];

   always_comb begin
      a[0] = (QW+1)'(oq_ff.w);
      a[1] = -((QW+1)'(oq_ff.x));
      a[2] = -((QW+1)'(oq_ff.y));
      a[3] = -((QW+1)'(oq_ff.z));
      b[0] = q1_ff.w; b[1] = q1_ff.x; b[2] = q1_ff.y; b[3] = q1_ff.z;
      dd[0] = '0; dd[1] = d1_ff[0]; dd[2] = d1_ff[1]; dd[3] = d1_ff[2];
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 1; j < 4; j++) begin
               tp_ff[i*3+j-1] <= PW'(a[i]) * PW'(dd[j]);
            end
            for (int j = 0; j < 4; j++) begin
               op2_ff[i*4+j] <= (2*QW)'(a[i]) * (2*QW)'(b[j]);
            end
         end
         f1_ff <= f0_ff;
      end
   end

   // stage 3: sum t, round, multiply by q0; sum o
   function automatic logic signed [PW+1:0] tx(input int i, input int j);
      return (PW+2)'(tp_ff[i*3+j-1]);
   endfunction

   logic signed [PW+1:0] ts [4];
   logic signed [TW-1:0] t [4];
   logic signed [TW+QW-1:0] rp_ff [12];
   logic signed [OW-1:0] os_ff [4];
   logic signed [QW-1:0] q0 [4];

   always_comb begin
      ts[0] = -tx(1,1) - tx(2,2) - tx(3,3);
      ts[1] =  tx(0,1) + tx(2,3) - tx(3,2);
      ts[2] =  tx(0,2) - tx(1,3) + tx(3,1);
      ts[3] =  tx(0,3) + tx(1,2) - tx(2,1);
      for (int i = 0; i < 4; i++) begin
         t[i] = prq_pkg::rnd_t(ts[i]);
      end
      q0[0] = oq_ff.w; q0[1] = oq_ff.x; q0[2] = oq_ff.y; q0[3] = oq_ff.z;
   end

   function automatic logic signed [OW-1:0] ox(input int i, input int j);
      return OW'(op2_ff[i*4+j]);
   endfunction

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         // products for x, y, z of t*q0: t0*q1,t1*q0,t2*q3,t3*q2 etc.
         rp_ff[0]  <= (TW+QW)'(t[0]) * (TW+QW)'(q0[1]);
         rp_ff[1]  <= (TW+QW)'(t[1]) * (TW+QW)'(q0[0]);
         rp_ff[2]  <= (TW+QW)'(t[2]) * (TW+QW)'(q0[3]);
         rp_ff[3]  <= (TW+QW)'(t[3]) * (TW+QW)'(q0[2]);
         rp_ff[4]  <= (TW+QW)'(t[0]) * (TW+QW)'(q0[2]);
         rp_ff[5]  <= (TW+QW)'(t[1]) * (TW+QW)'(q0[3]);
         rp_ff[6]  <= (TW+QW)'(t[2]) * (TW+QW)'(q0[0]);
         rp_ff[7]  <= (TW+QW)'(t[3]) * (TW+QW)'(q0[1]);
         rp_ff[8]  <= (TW+QW)'(t[0]) * (TW+QW)'(q0[3]);
         rp_ff[9]  <= (TW+QW)'(t[1]) * (TW+QW)'(q0[2]);
         rp_ff[10] <= (TW+QW)'(t[2]) * (TW+QW)'(q0[1]);
         rp_ff[11] <= (TW+QW)'(t[3]) * (TW+QW)'(q0[0]);
         os_ff[0] <= ox(0,0) - ox(1,1) - ox(2,2) - ox(3,3);
         os_ff[1] <= ox(0,1) + ox(1,0) + ox(2,3) - ox(3,2);
         os_ff[2] <= ox(0,2) - ox(1,3) + ox(2,0) + ox(3,1);
         os_ff[3] <= ox(0,3) + ox(1,2) - ox(2,1) + ox(3,0);
         f2_ff <= f1_ff;
      end
   end

   // stage 4: sum, round, saturate into the output register; a first sample gives zeros
   function automatic logic signed [SW-1:0] rx(input int k);
      return SW'(rp_ff[k]);
   endfunction

   logic signed [SW-1:0] rs [3];
   prq_pkg::rsp_type rsp_in;

   always_comb begin
      rs[0] = rx(0) + rx(1) + rx(2) - rx(3);
      rs[1] = rx(4) - rx(5) + rx(6) + rx(7);
      rs[2] = rx(8) + rx(9) - rx(10) + rx(11);
      if (f2_ff) begin
         rsp_in = '0;
         rsp_in.first_sample = 1'b1;
      end else begin
         rsp_in.rel_x  = prq_pkg::rnd_sat_pos(rs[0]);
         rsp_in.rel_y  = prq_pkg::rnd_sat_pos(rs[1]);
         rsp_in.rel_z  = prq_pkg::rnd_sat_pos(rs[2]);
         rsp_in.rel_w  = prq_pkg::rnd_sat_q(os_ff[0]);
         rsp_in.rel_qx = prq_pkg::rnd_sat_q(os_ff[1]);
         rsp_in.rel_qy = prq_pkg::rnd_sat_q(os_ff[2]);
         rsp_in.rel_qz = prq_pkg::rnd_sat_q(os_ff[3]);
         rsp_in.first_sample = 1'b0;
      end
   end

   prq_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (ld[3]) begin
         rsp_ff <= rsp_in;
         f3_ff  <= f2_ff;
      end
   end
   assign rsp_data = rsp_ff;

   a_origin_sticky: assert property (@(posedge clock) disable iff (reset)
      origin_valid_ff |=> origin_valid_ff) else $error("origin flag dropped");
   a_first_sets: assert property (@(posedge clock) disable iff (reset)
      (ld[0] && !origin_valid_ff) |=> origin_valid_ff) else $error("origin not latched");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(f3_ff)) else $error("output moved in stall");
endmodule

### rtl/prq_stage.sv
// pipeline control for one stage: valid bit and enable under back pressure
module prq_stage (
   input  logic clock,
   input  logic reset,
   input  logic up_valid,
   input  logic dn_ready,
   output logic up_ready,
   output logic load,
   output logic valid_ff
);
   logic valid_in;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end
endmodule
